/* src/vrcr_pkg.sv */
package vrcr_pkg;

  // defaults for the top-level parameters
  localparam int RING_BYTES_DEF   = 65536;
  localparam int SLOT_ALIGN_DEF   = 16;
  localparam int HEADER_BYTES_DEF = 8;

  // fixed field widths
  localparam int FIELD_W = 16;
  localparam int SZ_W    = 17;  // rounded-up byte count before the range check
  localparam int MEM_W   = 3 * FIELD_W;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BADSIZE = 2'd3;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DIV,
    ACT_MUL,
    ACT_PUSH_BAD,
    ACT_PUSH_NOSPACE,
    ACT_PUSH_WRITE,
    ACT_PUSH_MARK,
    ACT_PUSH_NOSPACE_WRAP,
    ACT_PUSH_WRITE0,
    ACT_POP_EMPTY,
    ACT_POP_READ,
    ACT_POP_OK,
    ACT_POP_SKIP,
    ACT_POP_SKIP_EMPTY
  } action_t;

  typedef struct packed {
    action_t act;
  } cmd_t;

  typedef struct packed {
    logic bad;        // size out of range
    logic nospace;    // not enough free bytes at the write offset
    logic need_wrap;  // record would run past the end of the ring
    logic nospace0;   // not enough free bytes starting at offset 0
    logic empty;      // read offset equals write offset
    logic wp_zero;    // write offset is 0
    logic mark;       // header read back is a wrap marker
    logic out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

/* src/vrcr_ram.sv */
module vrcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/vrcr_ctrl.sv */
module vrcr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_pop,
  output logic            in_tready,
  input  vrcr_pkg::stat_t st,
  output vrcr_pkg::cmd_t  cmd
);
  import vrcr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_CHK,
    S_CHK0,
    S_POP,
    S_POPW,
    S_POPW0
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.act   = ACT_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.act   = ACT_LOAD;
          state_nxt = in_pop ? S_POP : S_DIV;
        end
      end
      S_DIV: begin
        cmd.act   = ACT_DIV;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.act   = ACT_MUL;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (st.bad) begin
          if (st.out_free) begin
            cmd.act   = ACT_PUSH_BAD;
            state_nxt = S_IDLE;
          end
        end else if (st.nospace) begin
          if (st.out_free) begin
            cmd.act   = ACT_PUSH_NOSPACE;
            state_nxt = S_IDLE;
          end
        end else if (st.need_wrap) begin
          // marker write has no result of its own
          cmd.act   = ACT_PUSH_MARK;
          state_nxt = S_CHK0;
        end else if (st.out_free) begin
          cmd.act   = ACT_PUSH_WRITE;
          state_nxt = S_IDLE;
        end
      end
      S_CHK0: begin
        if (st.out_free) begin
          cmd.act   = st.nospace0 ? ACT_PUSH_NOSPACE_WRAP : ACT_PUSH_WRITE0;
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        if (st.empty) begin
          if (st.out_free) begin
            cmd.act   = ACT_POP_EMPTY;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.act   = ACT_POP_READ;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        if (st.mark) begin
          if (st.wp_zero) begin
            if (st.out_free) begin
              cmd.act   = ACT_POP_SKIP_EMPTY;
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.act   = ACT_POP_SKIP;
            state_nxt = S_POPW0;
          end
        end else if (st.out_free) begin
          cmd.act   = ACT_POP_OK;
          state_nxt = S_IDLE;
        end
      end
      S_POPW0: begin
        if (st.out_free) begin
          cmd.act   = st.mark ? ACT_POP_SKIP_EMPTY : ACT_POP_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

/* src/vrcr_dp.sv */
module vrcr_dp #(
  parameter int RING_BYTES   = vrcr_pkg::RING_BYTES_DEF,
  parameter int SLOT_ALIGN   = vrcr_pkg::SLOT_ALIGN_DEF,
  parameter int HEADER_BYTES = vrcr_pkg::HEADER_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [15:0]     cfg_wr_data,
  input  logic [31:0]     in_tdata,
  input  vrcr_pkg::cmd_t  cmd,
  output vrcr_pkg::stat_t st,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [55:0]     out_tdata,
  output logic [1:0]      out_tuser
);
  import vrcr_pkg::*;

  localparam int OFF_W      = $clog2(RING_BYTES);
  localparam int SLOT_COUNT = (RING_BYTES + SLOT_ALIGN - 1) / SLOT_ALIGN;
  localparam int AW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RESERVE    = (HEADER_BYTES > SLOT_ALIGN) ? HEADER_BYTES : SLOT_ALIGN;
  localparam int CW         = ((OFF_W >= SZ_W) ? OFF_W : SZ_W) + 2;
  localparam int SW         = ((AW >= FIELD_W) ? AW : FIELD_W) + 1;
  localparam int LG         = $clog2(SLOT_ALIGN);
  localparam int RCP_W      = SZ_W + 1;
  localparam int RCP_SH     = SZ_W + LG;
  localparam int PROD_W     = SZ_W + RCP_W;
  localparam int MUL_W      = SZ_W + LG + 1;
  // reciprocal of the alignment, exact for every numerator below 2**SZ_W
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(SLOT_ALIGN) - 64'd1) / 64'(SLOT_ALIGN));

  logic [FIELD_W-1:0] type_r, bytes_r, wmc_r;
  logic [SZ_W-1:0]    q_r, size_r;
  logic [OFF_W-1:0]   wp_r, rp_r;
  logic [AW-1:0]      wslot_r, rslot_r;
  logic               skip_r;
  logic               ov_r;
  logic [1:0]         ost_r;
  logic [FIELD_W-1:0] opay_r, otype_r, obytes_r;
  logic               owrap_r;

  logic [SZ_W-1:0]    numer, q_nxt, size_nxt;
  logic [PROD_W-1:0]  prod;
  logic [MUL_W-1:0]   scaled;
  logic [CW-1:0]      wp_c, rp_c, size_c, ring_c, free_c, free0_c, needed_c;
  logic [CW-1:0]      wsum, rsum, rbyte_nxt, pay_w, pay_r;
  logic [SW-1:0]      wslot_sum, rslot_sum, rslot_nxt;
  logic               wsum_end, rwrap;
  logic [MEM_W-1:0]   hdr_word, marker_word, rdata, wdata;
  logic [FIELD_W-1:0] rd_type, rd_size, rd_slots;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic               emit, res_wrap;
  logic [1:0]         res_st;
  logic [FIELD_W-1:0] res_pay, res_type, res_bytes;

  // size rounding: ceil(bytes / align) by reciprocal, then scale back
  assign numer    = SZ_W'(bytes_r) + SZ_W'(SLOT_ALIGN - 1);
  assign prod     = PROD_W'(numer) * PROD_W'(RECIP);
  assign q_nxt    = SZ_W'(prod >> RCP_SH);
  assign scaled   = MUL_W'(q_r) * MUL_W'(SLOT_ALIGN);
  assign size_nxt = SZ_W'(scaled);

  assign wp_c     = CW'(wp_r);
  assign rp_c     = CW'(rp_r);
  assign size_c   = CW'(size_r);
  assign ring_c   = CW'(RING_BYTES);
  assign needed_c = size_c + CW'(RESERVE);
  assign free_c   = (wp_c >= rp_c) ? (ring_c - (wp_c - rp_c) - CW'(1))
                                   : (rp_c - wp_c - CW'(1));
  assign free0_c  = (rp_c == '0) ? (ring_c - CW'(1)) : (rp_c - CW'(1));

  assign st.bad       = (bytes_r < FIELD_W'(HEADER_BYTES)) ||
                        (size_r > SZ_W'(16'hFFFF)) ||
                        (needed_c > ring_c - CW'(1));
  assign st.nospace   = free_c < needed_c;
  assign st.need_wrap = (wp_c + size_c) > ring_c;
  assign st.nospace0  = free0_c < size_c;
  assign st.empty     = rp_r == wp_r;
  assign st.wp_zero   = wp_r == '0;
  assign st.mark      = rd_size == '0;
  assign st.out_free  = !ov_r || out_tready;

  // header word: slot count, aligned size, type
  assign hdr_word    = {q_r[FIELD_W-1:0], size_r[FIELD_W-1:0], type_r};
  assign marker_word = {{(2 * FIELD_W){1'b0}}, wmc_r};
  assign rd_type     = rdata[FIELD_W-1:0];
  assign rd_size     = rdata[2*FIELD_W-1:FIELD_W];
  assign rd_slots    = rdata[3*FIELD_W-1:2*FIELD_W];

  assign wsum      = wp_c + size_c;
  assign wsum_end  = wsum == ring_c;
  assign wslot_sum = SW'(wslot_r) + SW'(q_r[FIELD_W-1:0]);
  assign rsum      = rp_c + CW'(rd_size);
  assign rwrap     = rsum >= ring_c;
  assign rbyte_nxt = rwrap ? (rsum - ring_c) : rsum;
  assign rslot_sum = SW'(rslot_r) + SW'(rd_slots);
  assign rslot_nxt = rwrap ? (rslot_sum - SW'(SLOT_COUNT)) : rslot_sum;
  assign pay_w     = wp_c + CW'(HEADER_BYTES);
  assign pay_r     = rp_c + CW'(HEADER_BYTES);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = wslot_r;
    raddr = rslot_r;
    wdata = hdr_word;
    case (cmd.act)
      ACT_PUSH_WRITE: begin
        we = 1'b1;
      end
      ACT_PUSH_MARK: begin
        we    = 1'b1;
        wdata = marker_word;
      end
      ACT_PUSH_WRITE0: begin
        we    = 1'b1;
        waddr = '0;
      end
      ACT_POP_READ: begin
        re = 1'b1;
      end
      ACT_POP_SKIP: begin
        re    = 1'b1;
        raddr = '0;
      end
      default: begin
      end
    endcase
  end

  vrcr_ram #(
    .WIDTH (MEM_W),
    .DEPTH (SLOT_COUNT)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    emit      = 1'b1;
    res_st    = ST_OK;
    res_pay   = '0;
    res_type  = '0;
    res_bytes = '0;
    res_wrap  = 1'b0;
    case (cmd.act)
      ACT_PUSH_BAD: begin
        res_st = ST_BADSIZE;
      end
      ACT_PUSH_NOSPACE: begin
        res_st = ST_NOSPACE;
      end
      ACT_PUSH_NOSPACE_WRAP: begin
        res_st   = ST_NOSPACE;
        res_wrap = 1'b1;
      end
      ACT_PUSH_WRITE: begin
        res_pay = FIELD_W'(pay_w);
      end
      ACT_PUSH_WRITE0: begin
        res_pay  = FIELD_W'(HEADER_BYTES);
        res_wrap = 1'b1;
      end
      ACT_POP_EMPTY: begin
        res_st = ST_EMPTY;
      end
      ACT_POP_SKIP_EMPTY: begin
        res_st   = ST_EMPTY;
        res_wrap = 1'b1;
      end
      ACT_POP_OK: begin
        res_pay   = FIELD_W'(pay_r);
        res_type  = rd_type;
        res_bytes = rd_size;
        res_wrap  = skip_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      wslot_r <= '0;
      rslot_r <= '0;
      wmc_r   <= '0;
      skip_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wmc_r <= cfg_wr_data;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      case (cmd.act)
        ACT_LOAD: begin
          skip_r <= 1'b0;
        end
        ACT_PUSH_WRITE: begin
          wp_r    <= wsum_end ? '0 : OFF_W'(wsum);
          wslot_r <= wsum_end ? '0 : AW'(wslot_sum);
        end
        ACT_PUSH_MARK: begin
          wp_r    <= '0;
          wslot_r <= '0;
        end
        ACT_PUSH_WRITE0: begin
          wp_r    <= OFF_W'(size_c);
          wslot_r <= AW'(q_r);
        end
        ACT_POP_OK: begin
          rp_r    <= OFF_W'(rbyte_nxt);
          rslot_r <= AW'(rslot_nxt);
        end
        ACT_POP_SKIP: begin
          rp_r    <= '0;
          rslot_r <= '0;
          skip_r  <= 1'b1;
        end
        ACT_POP_SKIP_EMPTY: begin
          rp_r    <= '0;
          rslot_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_LOAD: begin
        type_r  <= in_tdata[15:0];
        bytes_r <= in_tdata[31:16];
      end
      ACT_DIV: begin
        q_r <= q_nxt;
      end
      ACT_MUL: begin
        size_r <= size_nxt;
      end
      default: begin
      end
    endcase
    if (emit) begin
      ost_r    <= res_st;
      opay_r   <= res_pay;
      otype_r  <= res_type;
      obytes_r <= res_bytes;
      owrap_r  <= res_wrap;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {7'd0, owrap_r, obytes_r, otype_r, opay_r};

endmodule

/* src/variable_record_command_ring.sv */
// channel | dir | signals                          | contents
// cfg     | in  | cfg_wr_en, cfg_wr_data[15:0]     | wrap_marker_code
// in      | in  | in_tvalid/in_tready/tdata/tuser  | push or pop command
// out     | out | out_tvalid/out_tready/tdata/tuser| status and record info
//
// a push steps through accept, divide, scale and check, and a wrap marker adds a check at slot 0
// a pop steps through accept, read and finish; an empty ring ends at the read step, and a read of slot 0 adds a step
// the beat loads in the last of these steps
// reset clears both offsets and the marker code; the header ram is not cleared
// one item at a time; a new item is taken while the last result waits in the
// output register, and the finishing step holds while that register is full
module variable_record_command_ring #(
  parameter int RING_BYTES   = vrcr_pkg::RING_BYTES_DEF,
  parameter int SLOT_ALIGN   = vrcr_pkg::SLOT_ALIGN_DEF,
  parameter int HEADER_BYTES = vrcr_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // record_type[15:0], record_bytes[31:16]
  input  logic        in_tuser,   // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // payload_offset[15:0], popped_type[31:16],
                                  // popped_bytes[47:32], wrapped[48], zero[55:49]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import vrcr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  vrcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_pop    (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  vrcr_dp #(
    .RING_BYTES   (RING_BYTES),
    .SLOT_ALIGN   (SLOT_ALIGN),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .st          (st),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // one item at a time: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // a result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_PUSH_BAD || cmd.act == ACT_PUSH_NOSPACE ||
     cmd.act == ACT_PUSH_NOSPACE_WRAP || cmd.act == ACT_PUSH_WRITE ||
     cmd.act == ACT_PUSH_WRITE0 || cmd.act == ACT_POP_EMPTY ||
     cmd.act == ACT_POP_SKIP_EMPTY || cmd.act == ACT_POP_OK) |-> st.out_free)
    else $error("result overwrote a pending beat");

  // failed steps carry no offset or header
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[47:0] == 48'd0))
    else $error("non-ok result with nonzero fields");

endmodule
